[sv/vpcr_pkg.sv]
// Package for the vector path command resolver.
// Holds opcode and segment kind codes and the result and queue entry types.
// No dependencies.
`default_nettype none

package vpcr_pkg;

    localparam logic [3:0] OP_MOVE   = 4'd0;
    localparam logic [3:0] OP_LINE   = 4'd1;
    localparam logic [3:0] OP_HORIZ  = 4'd2;
    localparam logic [3:0] OP_VERT   = 4'd3;
    localparam logic [3:0] OP_CUBIC  = 4'd4;
    localparam logic [3:0] OP_SCUBIC = 4'd5;
    localparam logic [3:0] OP_QUAD   = 4'd6;
    localparam logic [3:0] OP_SQUAD  = 4'd7;
    localparam logic [3:0] OP_CONIC  = 4'd8;
    localparam logic [3:0] OP_ARC    = 4'd9;
    localparam logic [3:0] OP_CLOSE  = 4'd10;
    localparam logic [3:0] OP_NONE   = 4'd15;

    localparam logic [2:0] KIND_MOVE  = 3'd0;
    localparam logic [2:0] KIND_LINE  = 3'd1;
    localparam logic [2:0] KIND_QUAD  = 3'd2;
    localparam logic [2:0] KIND_CUBIC = 3'd3;
    localparam logic [2:0] KIND_CONIC = 3'd4;
    localparam logic [2:0] KIND_ARC   = 3'd5;
    localparam logic [2:0] KIND_CLOSE = 3'd6;
    localparam logic [2:0] KIND_ERROR = 3'd7;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] p0x;
        logic signed [31:0] p0y;
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] p3x;
        logic signed [31:0] p3y;
        logic signed [31:0] out_scalar;
        logic [1:0]         arc_flags;
        logic               last;
    } t_seg;

    typedef struct packed {
        t_seg               seg;
        logic               has_move;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
    } t_entry;

endpackage

`default_nettype wire

[sv/vpcr_cmd_if.sv]
// Command channel of the vector path command resolver.
// Carries valid, ready and one tokenized path command. No dependencies.
`default_nettype none

interface vpcr_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         opcode;
    logic               relative;
    logic               repeat_req;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] scalar;
    logic               major_arc;
    logic               sweep;

    modport source (
        output valid, opcode, relative, repeat_req, ax, ay, bx, by, cx, cy,
               scalar, major_arc, sweep,
        input  ready
    );

    modport sink (
        input  valid, opcode, relative, repeat_req, ax, ay, bx, by, cx, cy,
               scalar, major_arc, sweep,
        output ready
    );
endinterface

`default_nettype wire

[sv/vpcr_seg_if.sv]
// Segment channel of the vector path command resolver.
// Carries valid, ready and one absolute segment primitive. No dependencies.
`default_nettype none

interface vpcr_seg_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] p0x;
    logic signed [31:0] p0y;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] p3x;
    logic signed [31:0] p3y;
    logic signed [31:0] out_scalar;
    logic [1:0]         arc_flags;
    logic               last;

    modport source (
        output valid, kind, p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y,
               out_scalar, arc_flags, last,
        input  ready
    );

    modport sink (
        input  valid, kind, p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y,
               out_scalar, arc_flags, last,
        output ready
    );
endinterface

`default_nettype wire

[sv/vector_path_command_resolver.sv]
// Each command transfer writes its result into a register of the result queue.
// Throughput: one command per cycle while the queue is not full; a segment after
// a close adds an implicit move beat ahead of that command's segment.
// A two-entry result queue decouples the sides; ready falls only when it is full.
// Reset (synchronous, active low) clears the current point, subpath start,
// last control point, error flag and queue; the previous command becomes none.
`default_nettype none

module vector_path_command_resolver #(
    parameter int COORD_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    vpcr_cmd_if.sink    i_cmd,
    vpcr_seg_if.source  o_seg
);

    localparam int W      = COORD_WIDTH;
    localparam int EW     = (W > 32) ? W : 32;
    localparam int QIDX_W = $clog2(vpcr_pkg::QDEPTH);
    localparam int QCNT_W = $clog2(vpcr_pkg::QDEPTH + 1);

    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] f_clamp(input logic signed [31:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > EW'(CMAX)) return CMAX;
        if (e < EW'(CMIN)) return CMIN;
        return W'(e);
    endfunction

    function automatic logic signed [W-1:0] f_sadd(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) + (W+1)'(b);
        if (s[W] != s[W-1]) return s[W] ? CMIN : CMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] f_ssub(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) - (W+1)'(b);
        if (s[W] != s[W-1]) return s[W] ? CMIN : CMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] f_sabs(input logic signed [W-1:0] v);
        if (!v[W-1]) return v;
        if (v == CMIN) return CMAX;
        return -v;
    endfunction

    function automatic logic signed [31:0] f_out(input logic signed [W-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        return e[31:0];
    endfunction

    logic signed [W-1:0] r_cur_x, r_cur_y, r_start_x, r_start_y, r_ctrl_x, r_ctrl_y;
    logic signed [W-1:0] n_cur_x, n_cur_y, n_start_x, n_start_y, n_ctrl_x, n_ctrl_y;
    logic [3:0]          r_prev, n_prev;
    logic                r_failed, n_failed;

    vpcr_pkg::t_entry    r_q [vpcr_pkg::QDEPTH];
    logic [QIDX_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                r_phase;

    vpcr_pkg::t_entry    w_ent;
    vpcr_pkg::t_entry    w_head;
    vpcr_pkg::t_seg      w_beat;
    logic                w_push, w_pop, w_move_beat, w_err;

    logic signed [W-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy;
    logic signed [W-1:0] w_rx, w_ry, w_refl_x, w_refl_y, w_ex, w_ey;
    logic signed [W-1:0] w_c1x, w_c1y;

    assign i_cmd.ready = (r_cnt != QCNT_W'(vpcr_pkg::QDEPTH));
    assign w_push      = i_cmd.valid && i_cmd.ready;

    assign w_err = r_failed || (i_cmd.opcode > vpcr_pkg::OP_CLOSE)
                || ((r_prev == vpcr_pkg::OP_NONE)
                    && ((i_cmd.opcode != vpcr_pkg::OP_MOVE) || i_cmd.repeat_req))
                || ((i_cmd.opcode == vpcr_pkg::OP_CLOSE) && i_cmd.repeat_req)
                || ((i_cmd.opcode == vpcr_pkg::OP_CONIC) && (i_cmd.scalar <= 32'sd0));

    always_comb begin
        w_ax = f_clamp(i_cmd.ax);
        w_ay = f_clamp(i_cmd.ay);
        w_bx = f_clamp(i_cmd.bx);
        w_by = f_clamp(i_cmd.by);
        w_cx = f_clamp(i_cmd.cx);
        w_cy = f_clamp(i_cmd.cy);
        if (i_cmd.relative) begin
            w_ax = f_sadd(r_cur_x, w_ax);
            w_ay = f_sadd(r_cur_y, w_ay);
            w_bx = f_sadd(r_cur_x, w_bx);
            w_by = f_sadd(r_cur_y, w_by);
            w_cx = f_sadd(r_cur_x, w_cx);
            w_cy = f_sadd(r_cur_y, w_cy);
        end
        w_rx     = f_sabs(f_clamp(i_cmd.ax));
        w_ry     = f_sabs(f_clamp(i_cmd.ay));
        w_refl_x = f_sadd(r_cur_x, f_ssub(r_cur_x, r_ctrl_x));
        w_refl_y = f_sadd(r_cur_y, f_ssub(r_cur_y, r_ctrl_y));
        w_ex     = (i_cmd.opcode == vpcr_pkg::OP_VERT)  ? r_cur_x : w_cx;
        w_ey     = (i_cmd.opcode == vpcr_pkg::OP_HORIZ) ? r_cur_y : w_cy;
    end

    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_start_x = r_start_x;
        n_start_y = r_start_y;
        n_ctrl_x  = r_ctrl_x;
        n_ctrl_y  = r_ctrl_y;
        n_prev    = r_prev;
        n_failed  = r_failed;
        w_c1x     = r_cur_x;
        w_c1y     = r_cur_y;
        w_ent                = '0;
        w_ent.seg.out_scalar = vpcr_pkg::ONE_Q16;
        w_ent.seg.last       = 1'b1;
        if (w_err) begin
            w_ent.seg.kind       = vpcr_pkg::KIND_ERROR;
            w_ent.seg.out_scalar = '0;
            n_failed             = 1'b1;
        end else begin
            unique case (i_cmd.opcode)
                vpcr_pkg::OP_CLOSE: begin
                    w_ent.seg.kind = vpcr_pkg::KIND_CLOSE;
                    w_ent.seg.p0x  = f_out(r_cur_x);
                    w_ent.seg.p0y  = f_out(r_cur_y);
                    w_ent.seg.p1x  = f_out(r_start_x);
                    w_ent.seg.p1y  = f_out(r_start_y);
                    n_cur_x        = r_start_x;
                    n_cur_y        = r_start_y;
                    n_prev         = vpcr_pkg::OP_CLOSE;
                end
                vpcr_pkg::OP_MOVE: begin
                    if (i_cmd.repeat_req) begin
                        w_ent.seg.kind = vpcr_pkg::KIND_LINE;
                        w_ent.seg.p0x  = f_out(r_cur_x);
                        w_ent.seg.p0y  = f_out(r_cur_y);
                        w_ent.seg.p1x  = f_out(w_cx);
                        w_ent.seg.p1y  = f_out(w_cy);
                    end else begin
                        w_ent.seg.kind = vpcr_pkg::KIND_MOVE;
                        w_ent.seg.p0x  = f_out(w_cx);
                        w_ent.seg.p0y  = f_out(w_cy);
                        n_start_x      = w_cx;
                        n_start_y      = w_cy;
                    end
                    n_cur_x = w_cx;
                    n_cur_y = w_cy;
                    n_prev  = vpcr_pkg::OP_MOVE;
                end
                default: begin
                    if (r_prev == vpcr_pkg::OP_CLOSE) begin
                        w_ent.has_move = 1'b1;
                        w_ent.move_x   = f_out(r_cur_x);
                        w_ent.move_y   = f_out(r_cur_y);
                        n_start_x      = r_cur_x;
                        n_start_y      = r_cur_y;
                    end
                    w_ent.seg.p0x = f_out(r_cur_x);
                    w_ent.seg.p0y = f_out(r_cur_y);
                    n_cur_x       = w_cx;
                    n_cur_y       = w_cy;
                    n_prev        = i_cmd.opcode;
                    case (i_cmd.opcode) inside
                        vpcr_pkg::OP_LINE, vpcr_pkg::OP_HORIZ, vpcr_pkg::OP_VERT: begin
                            w_ent.seg.kind = vpcr_pkg::KIND_LINE;
                            w_ent.seg.p1x  = f_out(w_ex);
                            w_ent.seg.p1y  = f_out(w_ey);
                            n_cur_x        = w_ex;
                            n_cur_y        = w_ey;
                        end
                        vpcr_pkg::OP_CUBIC, vpcr_pkg::OP_SCUBIC: begin
                            if (i_cmd.opcode == vpcr_pkg::OP_CUBIC) begin
                                w_c1x = w_ax;
                                w_c1y = w_ay;
                            end else if ((r_prev == vpcr_pkg::OP_CUBIC)
                                      || (r_prev == vpcr_pkg::OP_SCUBIC)) begin
                                w_c1x = w_refl_x;
                                w_c1y = w_refl_y;
                            end
                            w_ent.seg.kind = vpcr_pkg::KIND_CUBIC;
                            w_ent.seg.p1x  = f_out(w_c1x);
                            w_ent.seg.p1y  = f_out(w_c1y);
                            w_ent.seg.p2x  = f_out(w_bx);
                            w_ent.seg.p2y  = f_out(w_by);
                            w_ent.seg.p3x  = f_out(w_cx);
                            w_ent.seg.p3y  = f_out(w_cy);
                            n_ctrl_x       = w_bx;
                            n_ctrl_y       = w_by;
                        end
                        vpcr_pkg::OP_QUAD, vpcr_pkg::OP_SQUAD: begin
                            if (i_cmd.opcode == vpcr_pkg::OP_QUAD) begin
                                w_c1x = w_ax;
                                w_c1y = w_ay;
                            end else if ((r_prev == vpcr_pkg::OP_QUAD)
                                      || (r_prev == vpcr_pkg::OP_SQUAD)) begin
                                w_c1x = w_refl_x;
                                w_c1y = w_refl_y;
                            end
                            w_ent.seg.kind = vpcr_pkg::KIND_QUAD;
                            w_ent.seg.p1x  = f_out(w_c1x);
                            w_ent.seg.p1y  = f_out(w_c1y);
                            w_ent.seg.p2x  = f_out(w_cx);
                            w_ent.seg.p2y  = f_out(w_cy);
                            n_ctrl_x       = w_c1x;
                            n_ctrl_y       = w_c1y;
                        end
                        vpcr_pkg::OP_CONIC: begin
                            w_ent.seg.kind       = vpcr_pkg::KIND_CONIC;
                            w_ent.seg.p1x        = f_out(w_ax);
                            w_ent.seg.p1y        = f_out(w_ay);
                            w_ent.seg.p2x        = f_out(w_cx);
                            w_ent.seg.p2y        = f_out(w_cy);
                            w_ent.seg.out_scalar = i_cmd.scalar;
                        end
                        default: begin
                            if ((w_rx == '0) || (w_ry == '0)) begin
                                w_ent.seg.kind = vpcr_pkg::KIND_LINE;
                                w_ent.seg.p1x  = f_out(w_cx);
                                w_ent.seg.p1y  = f_out(w_cy);
                            end else begin
                                w_ent.seg.kind       = vpcr_pkg::KIND_ARC;
                                w_ent.seg.p1x        = f_out(w_rx);
                                w_ent.seg.p1y        = f_out(w_ry);
                                w_ent.seg.p3x        = f_out(w_cx);
                                w_ent.seg.p3y        = f_out(w_cy);
                                w_ent.seg.out_scalar = i_cmd.scalar;
                                w_ent.seg.arc_flags  = {i_cmd.major_arc, i_cmd.sweep};
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb begin
        w_head      = r_q[r_rp];
        w_move_beat = w_head.has_move && !r_phase;
        w_beat      = w_head.seg;
        if (w_move_beat) begin
            w_beat            = '0;
            w_beat.kind       = vpcr_pkg::KIND_MOVE;
            w_beat.p0x        = w_head.move_x;
            w_beat.p0y        = w_head.move_y;
            w_beat.out_scalar = vpcr_pkg::ONE_Q16;
        end
    end

    assign w_pop = o_seg.valid && o_seg.ready && !w_move_beat;

    assign o_seg.valid      = (r_cnt != '0);
    assign o_seg.kind       = w_beat.kind;
    assign o_seg.p0x        = w_beat.p0x;
    assign o_seg.p0y        = w_beat.p0y;
    assign o_seg.p1x        = w_beat.p1x;
    assign o_seg.p1y        = w_beat.p1y;
    assign o_seg.p2x        = w_beat.p2x;
    assign o_seg.p2y        = w_beat.p2y;
    assign o_seg.p3x        = w_beat.p3x;
    assign o_seg.p3y        = w_beat.p3y;
    assign o_seg.out_scalar = w_beat.out_scalar;
    assign o_seg.arc_flags  = w_beat.arc_flags;
    assign o_seg.last       = w_beat.last;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_ctrl_x  <= '0;
            r_ctrl_y  <= '0;
            r_prev    <= vpcr_pkg::OP_NONE;
            r_failed  <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
            r_phase   <= 1'b0;
        end else begin
            if (w_push) begin
                r_cur_x   <= n_cur_x;
                r_cur_y   <= n_cur_y;
                r_start_x <= n_start_x;
                r_start_y <= n_start_y;
                r_ctrl_x  <= n_ctrl_x;
                r_ctrl_y  <= n_ctrl_y;
                r_prev    <= n_prev;
                r_failed  <= n_failed;
                r_wp      <= r_wp + QIDX_W'(1);
            end
            if (w_pop) begin
                r_rp    <= r_rp + QIDX_W'(1);
                r_phase <= 1'b0;
            end else if (o_seg.valid && o_seg.ready) begin
                r_phase <= 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

endmodule

`default_nettype wire

[sv/vpcr_checker.sv]
// Port-level checker for the vector path command resolver and its bind.
// Depends on vpcr_pkg for the segment kind codes.
`default_nettype none

module vpcr_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_seg_valid,
    input wire       i_seg_ready,
    input wire [2:0] i_seg_kind,
    input wire [1:0] i_seg_arc_flags,
    input wire       i_seg_last,
    input wire [31:0] i_seg_p0x
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_seg_valid)
        else $error("segment valid right after reset");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg_valid && (i_seg_kind == vpcr_pkg::KIND_ERROR)) |->
        (i_seg_last && (i_seg_p0x == 32'd0)))
        else $error("error result is not a final, cleared beat");

    a_inner_is_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg_valid && !i_seg_last) |-> (i_seg_kind == vpcr_pkg::KIND_MOVE))
        else $error("non-final beat is not an implicit move");

    a_inner_followed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg_valid && i_seg_ready && !i_seg_last) |=> i_seg_valid)
        else $error("implicit move transfer not followed by its segment");

    a_flags_arc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg_valid && (i_seg_kind != vpcr_pkg::KIND_ARC)) |->
        (i_seg_arc_flags == 2'd0))
        else $error("arc flags set on a non-arc segment");

endmodule

bind vector_path_command_resolver vpcr_checker u_vpcr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_seg_valid     (o_seg.valid),
    .i_seg_ready     (o_seg.ready),
    .i_seg_kind      (o_seg.kind),
    .i_seg_arc_flags (o_seg.arc_flags),
    .i_seg_last      (o_seg.last),
    .i_seg_p0x       (o_seg.p0x)
);

`default_nettype wire
